>>> hdl/euler_to_quaternion_assert.svh
// Assertion macros for the Euler angle to quaternion converter.
// Used by euler_to_quaternion; expects clk and rst in the including scope.
`ifndef EULER_TO_QUATERNION_ASSERT_SVH
`define EULER_TO_QUATERNION_ASSERT_SVH
`ifndef SYNTHESIS
`define E2Q_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define E2Q_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define E2Q_ASSERT(lbl, prop, msg)
`define E2Q_ASSERT_RST(lbl, prop, msg)
`endif
`endif

>>> hdl/ecq_pkg.sv
// Shared constants, pipeline control type and elaboration-time functions
// for the Euler angle to quaternion converter. No dependencies.
`default_nettype none
package ecq_pkg;

  localparam int CORDIC_STEPS_DEF = 24;
  localparam int WORD_BITS_DEF = 32;
  localparam int ANGLE_BITS = 32;
  localparam int QUAT_BITS = 32;
  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

  typedef struct packed {
    logic       valid;
    logic [2:0] neg;
  } ecq_ctl_t;

  function automatic logic [63:0] round_shr(input logic [63:0] v, input int k);
    logic [63:0] r;
    r = (v + (64'd1 << (k - 1))) >> k;
    return r;
  endfunction

  function automatic logic [63:0] mulshr(input logic [63:0] a, input logic [63:0] b,
                                         input int s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> s;
    return p[63:0];
  endfunction

  function automatic logic [63:0] atan_val(input int i, input int fb);
    logic [63:0] acc;
    logic [63:0] term;
    int k;
    acc = 64'd0;
    if (i == 0) begin
      acc = round_shr(PI_Q60, 62 - fb);
    end else begin
      for (k = 0; 62 - i * (2 * k + 1) >= 0; k++) begin
        term = (64'd1 << (62 - i * (2 * k + 1))) / 64'(2 * k + 1);
        if (k % 2 == 1) acc = acc - term;
        else acc = acc + term;
      end
      acc = round_shr(acc, 62 - fb);
    end
    return acc;
  endfunction

  function automatic logic [63:0] gain_val(input int steps, input int fb);
    logic [63:0] p;
    logic [63:0] y;
    logic [63:0] t;
    logic [63:0] u;
    logic [63:0] three;
    int i;
    p = 64'd1 << 61;
    y = 64'd5 << 58;
    three = 64'd3 << 61;
    for (i = 0; i < steps; i++) p = p + (p >> (2 * i));
    for (i = 0; i < 10; i++) begin
      t = mulshr(y, y, 61);
      t = mulshr(p, t, 61);
      u = (t >= three) ? 64'd0 : three - t;
      y = mulshr(y, u, 62);
    end
    return round_shr(y, 61 - fb);
  endfunction

  function automatic logic [63:0] pi_val(input int fb);
    return round_shr(PI_Q60, 60 - fb);
  endfunction

  function automatic logic [63:0] half_pi_val(input int fb);
    return round_shr(PI_Q60, 61 - fb);
  endfunction

endpackage
`default_nettype wire

>>> hdl/ecq_prep.sv
// Input stage: halves the three angles, reduces them to [-pi/2, pi/2] and
// loads the CORDIC start vectors. Depends on ecq_pkg.
`default_nettype none
module ecq_prep #(
  parameter int W = 32,
  parameter int STEPS = 24
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                en,
  input  wire logic                                in_valid,
  input  wire logic [3*ecq_pkg::ANGLE_BITS-1:0]    angles,
  output ecq_pkg::ecq_ctl_t                        ctl,
  output logic [2:0][W-1:0]                        x,
  output logic [2:0][W-1:0]                        y,
  output logic [2:0][W-1:0]                        z
);
  import ecq_pkg::*;

  localparam int F = W - 2;
  localparam int WZ = W + 3;
  localparam int LSH = (F >= 29) ? F - 29 : 0;
  localparam int RSH = (F < 29) ? 29 - F : 0;
  localparam logic signed [WZ-1:0] PI = WZ'(pi_val(F));
  localparam logic signed [WZ-1:0] HPI = WZ'(half_pi_val(F));
  localparam logic [W-1:0] GAIN = W'(gain_val(STEPS, F));

  logic signed [2:0][WZ-1:0] half;
  logic signed [2:0][WZ-1:0] red;
  logic [2:0] neg_next;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      half[j] = WZ'((64'($signed(angles[j*ANGLE_BITS +: ANGLE_BITS])) <<< LSH) >>> RSH);
      if ($signed(half[j]) > HPI) begin
        red[j] = half[j] - PI;
        neg_next[j] = 1'b1;
      end else if ($signed(half[j]) < -HPI) begin
        red[j] = half[j] + PI;
        neg_next[j] = 1'b1;
      end else begin
        red[j] = half[j];
        neg_next[j] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl.neg <= neg_next;
      for (int j = 0; j < 3; j++) begin
        x[j] <= GAIN;
        y[j] <= '0;
        z[j] <= red[j][W-1:0];
      end
    end
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (en) begin
      ctl.valid <= in_valid;
    end
  end

endmodule
`default_nettype wire

>>> hdl/ecq_cordic_cell.sv
// One CORDIC rotation step for the three angle lanes, registered.
// Depends on ecq_pkg.
`default_nettype none
module ecq_cordic_cell #(
  parameter int W = 32,
  parameter int STEP = 0
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire ecq_pkg::ecq_ctl_t   ctl_in,
  input  wire logic [2:0][W-1:0]   x_in,
  input  wire logic [2:0][W-1:0]   y_in,
  input  wire logic [2:0][W-1:0]   z_in,
  output ecq_pkg::ecq_ctl_t        ctl_out,
  output logic [2:0][W-1:0]        x_out,
  output logic [2:0][W-1:0]        y_out,
  output logic [2:0][W-1:0]        z_out
);
  import ecq_pkg::*;

  localparam int F = W - 2;
  localparam logic signed [W-1:0] ATAN = W'(atan_val(STEP, F));

  logic signed [2:0][W-1:0] xs;
  logic signed [2:0][W-1:0] ys;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      xs[j] = $signed(x_in[j]) >>> STEP;
      ys[j] = $signed(y_in[j]) >>> STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_out.neg <= ctl_in.neg;
      for (int j = 0; j < 3; j++) begin
        if (!z_in[j][W-1]) begin
          x_out[j] <= x_in[j] - ys[j];
          y_out[j] <= y_in[j] + xs[j];
          z_out[j] <= z_in[j] - ATAN;
        end else begin
          x_out[j] <= x_in[j] + ys[j];
          y_out[j] <= y_in[j] - xs[j];
          z_out[j] <= z_in[j] + ATAN;
        end
      end
    end
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out.valid <= ctl_in.valid;
    end
  end

endmodule
`default_nettype wire

>>> hdl/ecq_combine.sv
// Forms the quaternion from the half-angle sines and cosines in three
// registered stages: pair products, triple products, sum and saturation.
// Depends on ecq_pkg.
`default_nettype none
module ecq_combine #(
  parameter int W = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           en,
  input  wire ecq_pkg::ecq_ctl_t              ctl,
  input  wire logic [2:0][W-1:0]              cos_in,
  input  wire logic [2:0][W-1:0]              sin_in,
  output logic                                out_valid,
  output logic [3:0][ecq_pkg::QUAT_BITS-1:0]  quat
);
  import ecq_pkg::*;

  localparam int F = W - 2;
  localparam int SH = F - 30;
  localparam int SHR = (SH > 0) ? SH : 0;
  localparam int SHL = (SH < 0) ? -SH : 0;
  localparam int RPOS = (SHR > 0) ? SHR - 1 : 0;
  localparam int WV = (W + 1 + SHL > QUAT_BITS) ? W + 1 + SHL : QUAT_BITS + 1;
  localparam logic signed [WV-1:0] RND = (SHR > 0) ? (WV'(1) <<< RPOS) : '0;
  localparam logic signed [WV-1:0] ONE = WV'(1) <<< 30;

  function automatic logic signed [W-1:0] fmul(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic [W-1:0] ua;
    logic [W-1:0] ub;
    logic [2*W-1:0] pr;
    logic [W-1:0] m;
    ua = a[W-1] ? -a : a;
    ub = b[W-1] ? -b : b;
    pr = {{W{1'b0}}, ua} * {{W{1'b0}}, ub} + ((2*W)'(1) << (F - 1));
    m = W'(pr >> F);
    return (a[W-1] ^ b[W-1]) ? -m : m;
  endfunction

  function automatic logic [QUAT_BITS-1:0] to_out(input logic signed [W:0] v);
    logic signed [WV-1:0] t;
    t = ((WV'(v) + RND) >>> SHR) <<< SHL;
    if (t > ONE) t = ONE;
    if (t < -ONE) t = -ONE;
    return t[QUAT_BITS-1:0];
  endfunction

  logic signed [2:0][W-1:0] c;
  logic signed [2:0][W-1:0] s;
  logic signed [W-1:0] crcp, srsp, crsp, srcp, cy1, sy1;
  logic signed [7:0][W-1:0] tri_p;
  logic [1:0] vld;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      c[j] = ctl.neg[j] ? -$signed(cos_in[j]) : $signed(cos_in[j]);
      s[j] = ctl.neg[j] ? -$signed(sin_in[j]) : $signed(sin_in[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld <= {vld[0], ctl.valid};
      out_valid <= vld[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      crcp <= fmul(c[0], c[1]);
      srsp <= fmul(s[0], s[1]);
      crsp <= fmul(c[0], s[1]);
      srcp <= fmul(s[0], c[1]);
      cy1 <= c[2];
      sy1 <= s[2];
      tri_p[0] <= fmul(crcp, cy1);
      tri_p[1] <= fmul(srsp, sy1);
      tri_p[2] <= fmul(srcp, cy1);
      tri_p[3] <= fmul(crsp, sy1);
      tri_p[4] <= fmul(crsp, cy1);
      tri_p[5] <= fmul(srcp, sy1);
      tri_p[6] <= fmul(crcp, sy1);
      tri_p[7] <= fmul(srsp, cy1);
      quat[0] <= to_out((W+1)'($signed(tri_p[0])) + (W+1)'($signed(tri_p[1])));
      quat[1] <= to_out((W+1)'($signed(tri_p[2])) - (W+1)'($signed(tri_p[3])));
      quat[2] <= to_out((W+1)'($signed(tri_p[4])) + (W+1)'($signed(tri_p[5])));
      quat[3] <= to_out((W+1)'($signed(tri_p[6])) - (W+1)'($signed(tri_p[7])));
    end
  end

endmodule
`default_nettype wire

>>> hdl/euler_to_quaternion.sv
// Euler angle (ZYX) to quaternion converter. Roll, pitch and yaw arrive
// as one beat of Q4.28 radians; the block halves each angle, runs a
// CORDIC_STEPS-cell chain that rotates all three half angles in parallel,
// and forms w, x, y, z as Q2.30 saturated to plus or minus one. It takes a
// new beat every cycle while the output is not stalled; the pipeline runs through an
// input reduction stage, one cell per CORDIC step, and three product and output
// stages. The whole pipeline holds while an output beat waits.
// Depends on ecq_pkg, ecq_prep, ecq_cordic_cell and ecq_combine.
`default_nettype none
`include "euler_to_quaternion_assert.svh"
module euler_to_quaternion #(
  parameter int CORDIC_STEPS = ecq_pkg::CORDIC_STEPS_DEF,
  parameter int WORD_BITS = ecq_pkg::WORD_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  // roll_angle[31:0], pitch_angle[63:32], yaw_angle[95:64]
  input  wire logic [95:0]   s_tdata,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  // quat_w[31:0], quat_x[63:32], quat_y[95:64], quat_z[127:96]
  output logic [127:0]       m_tdata
);
  import ecq_pkg::*;

  localparam int W = WORD_BITS;

  logic en;
  ecq_ctl_t ctl [CORDIC_STEPS+1];
  logic [2:0][W-1:0] cx [CORDIC_STEPS+1];
  logic [2:0][W-1:0] cy [CORDIC_STEPS+1];
  logic [2:0][W-1:0] cz [CORDIC_STEPS+1];
  logic [3:0][QUAT_BITS-1:0] quat;

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tdata = quat;

  ecq_prep #(.W(W), .STEPS(CORDIC_STEPS)) u_prep (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_tvalid), .angles(s_tdata),
    .ctl(ctl[0]), .x(cx[0]), .y(cy[0]), .z(cz[0])
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    ecq_cordic_cell #(.W(W), .STEP(i)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .ctl_in(ctl[i]), .x_in(cx[i]), .y_in(cy[i]), .z_in(cz[i]),
      .ctl_out(ctl[i+1]), .x_out(cx[i+1]), .y_out(cy[i+1]), .z_out(cz[i+1])
    );
  end

  ecq_combine #(.W(W)) u_combine (
    .clk(clk), .rst(rst), .en(en), .ctl(ctl[CORDIC_STEPS]),
    .cos_in(cx[CORDIC_STEPS]), .sin_in(cy[CORDIC_STEPS]),
    .out_valid(m_tvalid), .quat(quat)
  );

  `E2Q_ASSERT_RST(a_reset_empty, rst |=> !m_tvalid, "output beat right after reset")
  `E2Q_ASSERT(a_w_range, m_tvalid |-> ($signed(m_tdata[31:0]) <= 32'sd1073741824 && $signed(m_tdata[31:0]) >= -32'sd1073741824), "quat_w out of range")
  `E2Q_ASSERT(a_z_range, m_tvalid |-> ($signed(m_tdata[127:96]) <= 32'sd1073741824 && $signed(m_tdata[127:96]) >= -32'sd1073741824), "quat_z out of range")
  `E2Q_ASSERT(a_stall_holds, (m_tvalid && !m_tready) |-> !s_tready, "input taken while output stalled")

endmodule
`default_nettype wire
